FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// At most one bit of a vector set.
`define PSRF_ONEHOT0(label, vec, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(vec)) \
		else $error(msg);

// Exactly one bit of a vector set.
`define PSRF_ONEHOT(label, vec, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) $onehot(vec)) \
		else $error(msg);

// Condition a implies condition b in the same cycle.
`define PSRF_IMPLY(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

`endif

FILE: rtl/psrf_pkg.sv
package psrf_pkg;
	localparam int BL_N  = 64;
	localparam int LRU_N = 64;
	localparam int LRU_W = $clog2(LRU_N);

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 36;
	localparam int QUO_W       = 35;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	// floor(2^61 / 1e9): the estimate it gives is at most two below the true quotient
	localparam logic [31:0] RECIP_NS   = 32'd2305843009;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
	localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
	localparam logic [6:0]  TCP_HDR_LEN  = 7'd20;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYN_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYN_WINDOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAP    = 3'd4;

	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_BL_ADD = 2'd1,
		OP_BL_DEL = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		VD_PASS  = 2'd0,
		VD_DROP  = 2'd1,
		VD_ABORT = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		RS_FILTERED_PASS = 4'd0,
		RS_DISABLED      = 4'd1,
		RS_NOT_IPV4      = 4'd2,
		RS_BLACKLIST     = 4'd3,
		RS_SYN_FLOOD     = 4'd4,
		RS_RATE_LIMIT    = 4'd5,
		RS_TRUNCATED     = 4'd6,
		RS_OP_DONE       = 4'd7,
		RS_BL_FULL       = 4'd8
	} reason_t;

	typedef struct packed {
		logic add;
		logic remove;
	} bl_cmd_t;

	typedef struct packed {
		logic             touch;
		logic [LRU_W-1:0] touch_rank;
		logic             fill;
		logic             data_we;
		logic [63:0]      stamp;
		logic [31:0]      value;
	} lru_cmd_t;
endpackage

FILE: rtl/per_source_packet_rate_filter_top.sv
// Flow: a taken request goes to S_EVAL; blacklist commands and early verdicts go on to
// S_OUT, a packet that opens a new bucket entry passes S_BKT_LOOK and S_BKT_SEL, and one
// that refills an existing bucket then waits in S_BKT_WAIT (product, reciprocal division
// by 1e9, fixup); a SYN packet first passes S_SYN_LOOK and S_SYN_UPD, where a drop ends it.
// Throughput: one request at a time; the next can be taken in the cycle after the result is loaded.
// Reset: arst_n clears all valid bits and returns config to its defaults at once, ranks return to entry order.
module per_source_packet_rate_filter_top import psrf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [63:0] timestamp_ns, [79:64] frame_length, [95:80] ethertype,
	// [99:96] ip_header_words, [107:100] ip_protocol, [108] tcp_syn,
	// [109] tcp_ack, [141:110] source_address, [143:142] zero
	input  logic [IN_TDATA_W-1:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] verdict, [5:2] reason, [7:6] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_SYN_LOOK,
		S_SYN_UPD,
		S_BKT_LOOK,
		S_BKT_SEL,
		S_BKT_WAIT,
		S_OUT
	} state_t;

	state_t   state_q;
	verdict_t res_verdict_q;
	reason_t  res_reason_q;

	logic        en_q;
	logic [31:0] syn_limit_q;
	logic [35:0] syn_window_q;
	logic [29:0] rate_q;
	logic [31:0] cap_q;

	op_t         op_q;
	logic [63:0] now_q;
	logic [15:0] flen_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [7:0]  proto_q;
	logic        syn_q;
	logic        ack_q;
	logic [31:0] src_q;

	logic             look_hit_q;
	logic [LRU_N-1:0] look_sel_q;
	logic [LRU_W-1:0] look_rank_q;
	logic [63:0]      look_stamp_q;
	logic [31:0]      look_value_q;

	// blacklist row
	bl_cmd_t         bl_cmd;
	logic [BL_N-1:0] bl_hit_v;
	logic [BL_N:0]   bl_free_c;
	logic            bl_any;

	// SYN and bucket rows
	lru_cmd_t         syn_cmd;
	lru_cmd_t         bkt_cmd;
	logic [LRU_N-1:0] syn_hit_v;
	logic [LRU_N-1:0] syn_lru_v;
	logic [LRU_N-1:0] bkt_hit_v;
	logic [LRU_N-1:0] bkt_lru_v;
	logic [LRU_W-1:0] syn_rank_a  [LRU_N];
	logic [63:0]      syn_stamp_a [LRU_N];
	logic [31:0]      syn_value_a [LRU_N];
	logic [LRU_W-1:0] bkt_rank_a  [LRU_N];
	logic [63:0]      bkt_stamp_a [LRU_N];
	logic [31:0]      bkt_value_a [LRU_N];

	logic [LRU_N-1:0] syn_sel;
	logic [LRU_N-1:0] bkt_sel;
	logic [LRU_W-1:0] syn_rank_m;
	logic [63:0]      syn_stamp_m;
	logic [31:0]      syn_value_m;
	logic [LRU_W-1:0] bkt_rank_m;
	logic [63:0]      bkt_stamp_m;
	logic [31:0]      bkt_value_m;

	logic [6:0]       l4_start;
	logic [63:0]      elapsed;
	logic             in_win;
	logic [31:0]      cnt_inc;
	logic             rf_start;
	logic             rf_done;
	logic [QUO_W-1:0] rf_quo;
	logic [35:0]      avail_sum;
	logic [31:0]      avail;

	assign s_tready = (state_q == S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b1;
			syn_limit_q  <= 32'd100;
			syn_window_q <= 36'(NS_PER_SEC);
			rate_q       <= 30'd10000;
			cap_q        <= 32'd10000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_ENABLE: en_q         <= cfg_wdata[0];
				CFG_SYN_LIMIT:     syn_limit_q  <= cfg_wdata[31:0];
				CFG_SYN_WINDOW:    syn_window_q <= cfg_wdata;
				CFG_REFILL_RATE:   rate_q       <= cfg_wdata[29:0];
				CFG_BUCKET_CAP:    cap_q        <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= op_t'(s_tuser);
			now_q   <= s_tdata[63:0];
			flen_q  <= s_tdata[79:64];
			etype_q <= s_tdata[95:80];
			ihl_q   <= s_tdata[99:96];
			proto_q <= s_tdata[107:100];
			syn_q   <= s_tdata[108];
			ack_q   <= s_tdata[109];
			src_q   <= s_tdata[141:110];
		end
	end

	// cell rows
	assign bl_free_c[0] = 1'b0;
	generate
		for (genvar g = 0; g < BL_N; g++) begin : g_bl
			psrf_bl_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.key     (src_q),
				.cmd     (bl_cmd),
				.free_in (bl_free_c[g]),
				.hit     (bl_hit_v[g]),
				.free_out(bl_free_c[g+1])
			);
		end
		for (genvar g = 0; g < LRU_N; g++) begin : g_lru
			psrf_lru_cell u_syn (
				.clk   (clk),
				.arst_n(arst_n),
				.idx   (LRU_W'(g)),
				.key   (src_q),
				.sel   (look_sel_q[g]),
				.cmd   (syn_cmd),
				.hit   (syn_hit_v[g]),
				.lru   (syn_lru_v[g]),
				.rank  (syn_rank_a[g]),
				.stamp (syn_stamp_a[g]),
				.value (syn_value_a[g])
			);
			psrf_lru_cell u_bkt (
				.clk   (clk),
				.arst_n(arst_n),
				.idx   (LRU_W'(g)),
				.key   (src_q),
				.sel   (look_sel_q[g]),
				.cmd   (bkt_cmd),
				.hit   (bkt_hit_v[g]),
				.lru   (bkt_lru_v[g]),
				.rank  (bkt_rank_a[g]),
				.stamp (bkt_stamp_a[g]),
				.value (bkt_value_a[g])
			);
		end
	endgenerate

	assign bl_any  = |bl_hit_v;
	assign syn_sel = (|syn_hit_v) ? syn_hit_v : syn_lru_v;
	assign bkt_sel = (|bkt_hit_v) ? bkt_hit_v : bkt_lru_v;

	// read out the selected entry of each row
	always_comb begin
		syn_rank_m  = '0;
		syn_stamp_m = '0;
		syn_value_m = '0;
		bkt_rank_m  = '0;
		bkt_stamp_m = '0;
		bkt_value_m = '0;
		for (int i = 0; i < LRU_N; i++) begin
			if (syn_sel[i]) begin
				syn_rank_m  = syn_rank_m  | syn_rank_a[i];
				syn_stamp_m = syn_stamp_m | syn_stamp_a[i];
				syn_value_m = syn_value_m | syn_value_a[i];
			end
			if (bkt_sel[i]) begin
				bkt_rank_m  = bkt_rank_m  | bkt_rank_a[i];
				bkt_stamp_m = bkt_stamp_m | bkt_stamp_a[i];
				bkt_value_m = bkt_value_m | bkt_value_a[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SYN_LOOK) begin
			look_hit_q   <= |syn_hit_v;
			look_sel_q   <= syn_sel;
			look_rank_q  <= syn_rank_m;
			look_stamp_q <= syn_stamp_m;
			look_value_q <= syn_value_m;
		end else if (state_q == S_BKT_LOOK) begin
			look_hit_q   <= |bkt_hit_v;
			look_sel_q   <= bkt_sel;
			look_rank_q  <= bkt_rank_m;
			look_stamp_q <= bkt_stamp_m;
			look_value_q <= bkt_value_m;
		end
	end

	assign l4_start  = 7'd14 + {1'b0, ihl_q, 2'b0};
	assign elapsed   = now_q - look_stamp_q;
	assign in_win    = elapsed < {28'b0, syn_window_q};
	assign cnt_inc   = (look_value_q == 32'hFFFF_FFFF) ? look_value_q : look_value_q + 32'd1;
	assign avail_sum = {4'b0, look_value_q} + {1'b0, rf_quo};
	assign avail     = (avail_sum > {4'b0, cap_q}) ? cap_q : avail_sum[31:0];
	assign rf_start  = (state_q == S_BKT_SEL) && look_hit_q;

	psrf_refill u_refill (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rf_start),
		.elapsed (elapsed),
		.rate    (rate_q),
		.done    (rf_done),
		.quotient(rf_quo)
	);

	// row commands
	always_comb begin
		bl_cmd.add    = (state_q == S_EVAL) && (op_q == OP_BL_ADD) && !bl_any;
		bl_cmd.remove = (state_q == S_EVAL) && (op_q == OP_BL_DEL);

		syn_cmd            = '0;
		syn_cmd.touch_rank = look_rank_q;
		if (state_q == S_SYN_UPD) begin
			syn_cmd.touch   = 1'b1;
			syn_cmd.fill    = !look_hit_q;
			syn_cmd.data_we = 1'b1;
			if (look_hit_q && in_win) begin
				syn_cmd.stamp = look_stamp_q;
				syn_cmd.value = cnt_inc;
			end else begin
				// new source or new window: restart the count
				syn_cmd.stamp = now_q;
				syn_cmd.value = 32'd1;
			end
		end

		bkt_cmd            = '0;
		bkt_cmd.touch_rank = look_rank_q;
		bkt_cmd.stamp      = now_q;
		if ((state_q == S_BKT_SEL) && !look_hit_q) begin
			bkt_cmd.touch   = 1'b1;
			bkt_cmd.fill    = 1'b1;
			bkt_cmd.data_we = 1'b1;
			bkt_cmd.value   = (cap_q != 32'd0) ? cap_q - 32'd1 : 32'd0;
		end else if ((state_q == S_BKT_WAIT) && rf_done) begin
			// an empty bucket keeps its tokens and time
			bkt_cmd.touch   = 1'b1;
			bkt_cmd.data_we = (avail != 32'd0);
			bkt_cmd.value   = avail - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			res_verdict_q <= VD_PASS;
			res_reason_q  <= RS_FILTERED_PASS;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
		end else begin
			if (m_tready && (state_q != S_OUT)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q       <= S_OUT;
					res_verdict_q <= VD_PASS;
					res_reason_q  <= RS_OP_DONE;
					case (op_q)
						OP_BL_ADD: begin
							if (!bl_any && !bl_free_c[BL_N]) begin
								res_reason_q <= RS_BL_FULL;
							end
						end
						OP_PACKET: begin
							if (!en_q) begin
								res_reason_q <= RS_DISABLED;
							end else if (flen_q < ETH_HDR_LEN) begin
								res_verdict_q <= VD_ABORT;
								res_reason_q  <= RS_TRUNCATED;
							end else if (etype_q != ETYPE_IPV4) begin
								res_reason_q <= RS_NOT_IPV4;
							end else if ((flen_q < IPV4_MIN_LEN) ||
								({9'b0, l4_start} > flen_q)) begin
								res_verdict_q <= VD_ABORT;
								res_reason_q  <= RS_TRUNCATED;
							end else if (bl_any) begin
								res_verdict_q <= VD_DROP;
								res_reason_q  <= RS_BLACKLIST;
							end else if ((proto_q == PROTO_TCP) &&
								({9'b0, l4_start + TCP_HDR_LEN} > flen_q)) begin
								res_verdict_q <= VD_ABORT;
								res_reason_q  <= RS_TRUNCATED;
							end else if ((proto_q == PROTO_TCP) && syn_q && !ack_q) begin
								state_q <= S_SYN_LOOK;
							end else begin
								state_q <= S_BKT_LOOK;
							end
						end
						default: ;
					endcase
				end
				S_SYN_LOOK: state_q <= S_SYN_UPD;
				S_SYN_UPD: begin
					if (look_hit_q && in_win && (cnt_inc > syn_limit_q)) begin
						res_verdict_q <= VD_DROP;
						res_reason_q  <= RS_SYN_FLOOD;
						state_q       <= S_OUT;
					end else begin
						state_q <= S_BKT_LOOK;
					end
				end
				S_BKT_LOOK: state_q <= S_BKT_SEL;
				S_BKT_SEL: begin
					res_verdict_q <= VD_PASS;
					res_reason_q  <= RS_FILTERED_PASS;
					state_q       <= look_hit_q ? S_BKT_WAIT : S_OUT;
				end
				S_BKT_WAIT: begin
					if (rf_done) begin
						if (avail == 32'd0) begin
							res_verdict_q <= VD_DROP;
							res_reason_q  <= RS_RATE_LIMIT;
						end else begin
							res_verdict_q <= VD_PASS;
							res_reason_q  <= RS_FILTERED_PASS;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {2'b0, res_reason_q, res_verdict_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	`PSRF_ONEHOT0(a_syn_hit_unique, syn_hit_v, "SYN row holds a source twice")
	`PSRF_ONEHOT0(a_bkt_hit_unique, bkt_hit_v, "bucket row holds a source twice")
	`PSRF_ONEHOT(a_syn_lru_one, syn_lru_v, "SYN ranks not a permutation")
	`PSRF_ONEHOT(a_bkt_lru_one, bkt_lru_v, "bucket ranks not a permutation")
	`PSRF_IMPLY(a_rf_done_wait, rf_done, state_q == S_BKT_WAIT, "refill done outside wait")
endmodule

FILE: rtl/psrf_bl_cell.sv
module psrf_bl_cell import psrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] key,
	input  bl_cmd_t     cmd,
	input  logic        free_in,
	output logic        hit,
	output logic        free_out
);
	logic        valid_q;
	logic [31:0] addr_q;
	logic        take;

	assign hit      = valid_q && (addr_q == key);
	assign take     = cmd.add && !valid_q && !free_in;
	assign free_out = free_in || !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (cmd.remove && hit) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q <= key;
		end
	end
endmodule

FILE: rtl/psrf_lru_cell.sv
module psrf_lru_cell import psrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LRU_W-1:0] idx,
	input  logic [31:0]      key,
	input  logic             sel,
	input  lru_cmd_t         cmd,
	output logic             hit,
	output logic             lru,
	output logic [LRU_W-1:0] rank,
	output logic [63:0]      stamp,
	output logic [31:0]      value
);
	logic             valid_q;
	logic [LRU_W-1:0] rank_q;
	logic [31:0]      addr_q;
	logic [63:0]      stamp_q;
	logic [31:0]      value_q;

	assign hit   = valid_q && (addr_q == key);
	assign lru   = (rank_q == LRU_W'(LRU_N - 1));
	assign rank  = rank_q;
	assign stamp = stamp_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= idx;
		end else begin
			if (cmd.fill && sel) begin
				valid_q <= 1'b1;
			end
			// move the touched entry to the front, age the ones ahead of it
			if (cmd.touch) begin
				if (sel) begin
					rank_q <= '0;
				end else if (rank_q < cmd.touch_rank) begin
					rank_q <= rank_q + LRU_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill && sel) begin
			addr_q <= key;
		end
		if (cmd.data_we && sel) begin
			stamp_q <= cmd.stamp;
			value_q <= cmd.value;
		end
	end
endmodule

FILE: rtl/psrf_refill.sv
module psrf_refill import psrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      elapsed,
	input  logic [29:0]      rate,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);
	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_RLO,
		U_RHI,
		U_REM,
		U_FIX
	} u_state_t;

	u_state_t         ust_q;
	logic [1:0]       cnt_q;
	logic [63:0]      el_q;
	logic [63:0]      acc_q;
	logic [63:0]      plo_q;
	logic [QUO_W-1:0] est_q;
	logic [31:0]      rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             done_q;
	logic [45:0]      pp;
	logic [63:0]      pp_sh;
	logic [31:0]      mop;
	logic [63:0]      rprod;
	logic [95:0]      psum;
	logic [31:0]      back;

	assign pp    = el_q[15:0] * rate;
	// one 32 by 32 multiplier, low half of the product first, high half next
	assign mop   = (ust_q == U_RLO) ? acc_q[31:0] : acc_q[63:32];
	assign rprod = mop * RECIP_NS;
	assign psum  = {rprod, 32'b0} + {32'b0, plo_q};
	// remainder fits in 32 bits, so the low bits of the back-product suffice
	assign back  = est_q[31:0] * NS_PER_SEC;

	always_comb begin
		case (cnt_q)
			2'd0:    pp_sh = {18'b0, pp};
			2'd1:    pp_sh = {2'b0, pp, 16'b0};
			2'd2:    pp_sh = {pp[31:0], 32'b0};
			default: pp_sh = {pp[15:0], 48'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q  <= U_IDLE;
			cnt_q  <= '0;
			el_q   <= '0;
			acc_q  <= '0;
			plo_q  <= '0;
			est_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ust_q)
				U_IDLE: begin
					if (start) begin
						el_q  <= elapsed;
						acc_q <= '0;
						cnt_q <= '0;
						ust_q <= U_MUL;
					end
				end
				U_MUL: begin
					// one 16-bit slice of elapsed per cycle, product wraps at 64 bits
					acc_q <= acc_q + pp_sh;
					el_q  <= {16'b0, el_q[63:16]};
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						ust_q <= U_RLO;
					end
				end
				U_RLO: begin
					plo_q <= rprod;
					ust_q <= U_RHI;
				end
				U_RHI: begin
					// quotient estimate from the reciprocal, short by at most two
					est_q <= psum[95:61];
					ust_q <= U_REM;
				end
				U_REM: begin
					rem_q <= acc_q[31:0] - back;
					ust_q <= U_FIX;
				end
				U_FIX: begin
					if (rem_q >= {1'b0, NS_PER_SEC, 1'b0}) begin
						quo_q <= est_q + QUO_W'(2);
					end else if (rem_q >= {2'b0, NS_PER_SEC}) begin
						quo_q <= est_q + QUO_W'(1);
					end else begin
						quo_q <= est_q;
					end
					done_q <= 1'b1;
					ust_q  <= U_IDLE;
				end
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
